// ===== rtl/nrg_pkg.sv =====
// Shared types and constants of the nuclear repulsion gradient unit.
package nrg_pkg;

  localparam int MAX_ATOMS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CHARGE_W      = 7;
  localparam int IDX_OUT_W     = 4;
  localparam int TERM_W        = 41;
  localparam logic [TERM_W-1:0] TERM_CAP = 41'h100_0000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
    logic [CHARGE_W-1:0]       nuclear_charge;
    logic                      last_atom;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]      atom_idx;
    logic signed [COORD_W-1:0] grad_x;
    logic signed [COORD_W-1:0] grad_y;
    logic signed [COORD_W-1:0] grad_z;
    logic                      saturated;
    logic                      coincident;
    logic                      row_last;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [CHARGE_W-1:0]       charge;
  } atom_t;

  typedef struct packed {
    atom_t a;
    atom_t b;
  } pair_req_t;

  typedef struct packed {
    logic [2:0][TERM_W-1:0] term;
    logic [2:0]             pos;
    logic                   clip;
    logic                   coin;
  } pair_res_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_RD_A, ST_CAP_A, ST_RD_B, ST_CAP_B, ST_PAIR, ST_ROW, ST_OUT
  } ctl_state_e;

  typedef enum logic [3:0] {
    PS_IDLE, PS_ABS, PS_NORM, PS_SHIFT, PS_SQ, PS_SQRT, PS_CDIV, PS_MUL, PS_QDIV, PS_DONE
  } pair_state_e;

endpackage

// ===== rtl/nrg_stream_if.sv =====
// Valid/ready stream interface carrying one payload transaction per handshake.
interface nrg_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/nrg_atom_store.sv =====
// Atom store: one synchronous memory with one write and one registered read port.
module nrg_atom_store #(
  parameter int MAX_ATOMS = nrg_pkg::MAX_ATOMS_DEF
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(MAX_ATOMS)-1:0] waddr_i,
  input  nrg_pkg::atom_t               wdata_i,
  input  logic [$clog2(MAX_ATOMS)-1:0] raddr_i,
  output nrg_pkg::atom_t               rdata_o
);

  nrg_pkg::atom_t mem_q [MAX_ATOMS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/nrg_pair_unit.sv =====
// Pair unit: iterative evaluation of one pair term on three axes.
module nrg_pair_unit #(
  parameter int FRAC_BITS = nrg_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  nrg_pkg::pair_req_t  req_i,
  output logic                done_o,
  output nrg_pkg::pair_res_t  res_o
);

  localparam int IterBase = 3 * FRAC_BITS + 34;
  localparam int CntW     = $clog2(IterBase + 1);
  localparam int SqrtLast = 30;
  localparam int CdivLast = 59;
  localparam int TermW    = nrg_pkg::TERM_W;

  nrg_pkg::pair_state_e state_q, state_d;

  logic signed [32:0] d_q [3];
  logic [32:0]        mag_q [3];
  logic [2:0]         pos_q;
  logic [3:0]         k_q;
  logic [19:0]        u_q [3];
  logic [13:0]        zz_q;
  logic [41:0]        s_q;
  logic [61:0]        v_q;
  logic [32:0]        srem_q;
  logic [30:0]        root_q;
  logic [59:0]        nsh_q;
  logic [30:0]        crem_q;
  logic [59:0]        c_q;
  logic [63:0]        p_q;
  logic [41:0]        qrem_q;
  logic [TermW-1:0]   q_q;
  logic               over_q;
  logic [2:0][TermW-1:0] term_q;
  logic               clip_q, coin_q;
  logic [1:0]         ax_q;
  logic [CntW-1:0]    cnt_q;

  // Combinational helpers.
  logic [32:0]     mag_or;
  logic [5:0]      hb;
  logic [3:0]      k_calc;
  logic [41:0]     s_sum;
  logic [34:0]     rem4, trial;
  logic            sq_ge;
  logic [31:0]     cr2;
  logic            c_ge;
  logic [42:0]     qr2;
  logic            q_ge;
  logic [TermW:0]  qn;
  logic            over_n;
  logic [CntW-1:0] q_last;
  logic [1:0]      ax_nx;

  assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];

  always_comb begin
    hb = '0;
    for (int i = 0; i < 33; i++) begin
      if (mag_or[i]) begin
        hb = 6'(i);
      end
    end
    k_calc = (hb > 6'd19) ? 4'(hb - 6'd19) : 4'd0;
  end

  assign s_sum  = s_q + 42'(u_q[ax_q] * u_q[ax_q]);
  assign rem4   = {srem_q, v_q[61:60]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_ge  = rem4 >= trial;
  assign cr2    = {crem_q, nsh_q[59]};
  assign c_ge   = cr2 >= {1'b0, root_q};
  assign qr2    = {qrem_q, p_q[63]};
  assign q_ge   = qr2 >= {1'b0, s_q};
  assign qn     = {q_q, q_ge};
  assign over_n = over_q | (qn > {1'b0, nrg_pkg::TERM_CAP});
  assign q_last = CntW'(IterBase - 1) - CntW'({k_q, 1'b0});
  assign ax_nx  = ax_q + 2'd1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      nrg_pkg::PS_IDLE:  if (start_i) state_d = nrg_pkg::PS_ABS;
      nrg_pkg::PS_ABS:   state_d = nrg_pkg::PS_NORM;
      nrg_pkg::PS_NORM:  state_d = (mag_or == '0) ? nrg_pkg::PS_DONE : nrg_pkg::PS_SHIFT;
      nrg_pkg::PS_SHIFT: state_d = nrg_pkg::PS_SQ;
      nrg_pkg::PS_SQ:    if (ax_q == 2'd2) state_d = nrg_pkg::PS_SQRT;
      nrg_pkg::PS_SQRT:  if (cnt_q == CntW'(SqrtLast)) state_d = nrg_pkg::PS_CDIV;
      nrg_pkg::PS_CDIV:  if (cnt_q == CntW'(CdivLast)) state_d = nrg_pkg::PS_MUL;
      nrg_pkg::PS_MUL:   state_d = nrg_pkg::PS_QDIV;
      nrg_pkg::PS_QDIV: begin
        if (cnt_q == q_last) begin
          state_d = (ax_q == 2'd2) ? nrg_pkg::PS_DONE : nrg_pkg::PS_CDIV;
        end
      end
      nrg_pkg::PS_DONE:  state_d = nrg_pkg::PS_IDLE;
      default:           state_d = nrg_pkg::PS_IDLE;
    endcase
  end

  always_comb begin
    done_o     = (state_q == nrg_pkg::PS_DONE);
    res_o.term = term_q;
    res_o.pos  = pos_q;
    res_o.clip = clip_q;
    res_o.coin = coin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nrg_pkg::PS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      nrg_pkg::PS_IDLE: begin
        if (start_i) begin
          d_q[0] <= 33'(req_i.a.x) - 33'(req_i.b.x);
          d_q[1] <= 33'(req_i.a.y) - 33'(req_i.b.y);
          d_q[2] <= 33'(req_i.a.z) - 33'(req_i.b.z);
          zz_q   <= 14'(req_i.a.charge * req_i.b.charge);
          clip_q <= 1'b0;
          coin_q <= 1'b0;
        end
      end
      nrg_pkg::PS_ABS: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= d_q[i][32] ? 33'(-d_q[i]) : 33'(d_q[i]);
          pos_q[i] <= !d_q[i][32] && (d_q[i] != '0);
        end
      end
      nrg_pkg::PS_NORM: begin
        k_q    <= k_calc;
        coin_q <= (mag_or == '0);
      end
      nrg_pkg::PS_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          u_q[i] <= 20'(mag_q[i] >> k_q);
        end
        s_q  <= '0;
        ax_q <= 2'd0;
      end
      nrg_pkg::PS_SQ: begin
        s_q <= s_sum;
        if (ax_q == 2'd2) begin
          v_q    <= {s_sum, 20'b0};
          srem_q <= '0;
          root_q <= '0;
          cnt_q  <= '0;
          ax_q   <= 2'd0;
        end else begin
          ax_q <= ax_nx;
        end
      end
      nrg_pkg::PS_SQRT: begin
        if (sq_ge) begin
          srem_q <= 33'(rem4 - trial);
          root_q <= {root_q[29:0], 1'b1};
        end else begin
          srem_q <= rem4[32:0];
          root_q <= {root_q[29:0], 1'b0};
        end
        v_q   <= {v_q[59:0], 2'b00};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(SqrtLast)) begin
          nsh_q  <= {u_q[0], 40'b0};
          crem_q <= '0;
          c_q    <= '0;
          cnt_q  <= '0;
        end
      end
      nrg_pkg::PS_CDIV: begin
        crem_q <= c_ge ? 31'(cr2 - {1'b0, root_q}) : cr2[30:0];
        c_q    <= {c_q[58:0], c_ge};
        nsh_q  <= {nsh_q[58:0], 1'b0};
        cnt_q  <= cnt_q + 1'b1;
      end
      nrg_pkg::PS_MUL: begin
        p_q    <= 64'(zz_q * c_q[49:0]);
        qrem_q <= '0;
        q_q    <= '0;
        over_q <= 1'b0;
        cnt_q  <= '0;
      end
      nrg_pkg::PS_QDIV: begin
        qrem_q <= q_ge ? 42'(qr2 - {1'b0, s_q}) : qr2[41:0];
        q_q    <= qn[TermW-1:0];
        over_q <= over_n;
        p_q    <= {p_q[62:0], 1'b0};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == q_last) begin
          term_q[ax_q] <= over_n ? nrg_pkg::TERM_CAP : qn[TermW-1:0];
          clip_q       <= clip_q | over_n;
          if (ax_q != 2'd2) begin
            ax_q   <= ax_nx;
            nsh_q  <= {u_q[ax_nx], 40'b0};
            crem_q <= '0;
            c_q    <= '0;
            cnt_q  <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/nuclear_repulsion_gradient_unit.sv =====
// Top level of the nuclear repulsion gradient unit: control, accumulation and result rows.
// Atoms arrive one per input transaction and are written into the atom store; a store that is
// full drops further atoms, but a transaction marked last_atom still starts the run. On the
// last atom, each atom A is read once, then every other atom B is read and handed to the pair
// unit, whose term is added to or subtracted from three 64-bit accumulators unless the pair is
// coincident. The pair unit is a bit-serial sequencer and sets the pace; one pair is finished
// before the next atom B is read. Each row also reads atom A, steps past itself, builds and
// offers the row, and waits while the receiver stalls. A run over N atoms takes N*(N-1) pair
// evaluations. Each row is saturated to 32 bits and offered as one output transaction; the next
// atom's sums start once that row is taken. Input is accepted only in the load phase, and the
// store is empty again after the final row.
module nuclear_repulsion_gradient_unit #(
  parameter int MAX_ATOMS = nrg_pkg::MAX_ATOMS_DEF,
  parameter int FRAC_BITS = nrg_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  nrg_stream_if.sink    in_i,
  nrg_stream_if.source  out_o
);

  localparam int IdxW    = $clog2(MAX_ATOMS);
  localparam int CntW    = $clog2(MAX_ATOMS + 1);
  localparam int IdxOutW = nrg_pkg::IDX_OUT_W;
  localparam int CoordW  = nrg_pkg::COORD_W;

  nrg_pkg::ctl_state_e state_q, state_d;

  logic [CntW-1:0]       cnt_q;
  logic [IdxW-1:0]       a_q, b_q;
  nrg_pkg::atom_t        atom_a_q;
  logic signed [63:0]    acc_q [3];
  logic                  clip_q, coin_q;
  nrg_pkg::out_item_t    row_q;

  // Control strobes from the output decoder.
  logic                  in_acc, out_acc, store_we, pair_start;
  logic [IdxW-1:0]       rd_addr;
  logic                  last_b, last_a;

  nrg_pkg::atom_t        wr_atom, rd_atom;
  nrg_pkg::pair_req_t    pair_req;
  nrg_pkg::pair_res_t    pair_res;
  logic                  pair_done;

  // Saturation of the finished sums.
  logic [2:0][CoordW-1:0] sat_val;
  logic [2:0]             sat_hit;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign last_b  = (CntW'(b_q) + 1'b1) == cnt_q;
  assign last_a  = (CntW'(a_q) + 1'b1) == cnt_q;

  assign wr_atom.x      = in_i.data.x_coord;
  assign wr_atom.y      = in_i.data.y_coord;
  assign wr_atom.z      = in_i.data.z_coord;
  assign wr_atom.charge = in_i.data.nuclear_charge;

  assign pair_req.a = atom_a_q;
  assign pair_req.b = rd_atom;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      nrg_pkg::ST_LOAD:  if (in_acc && in_i.data.last_atom) state_d = nrg_pkg::ST_RD_A;
      nrg_pkg::ST_RD_A:  state_d = nrg_pkg::ST_CAP_A;
      nrg_pkg::ST_CAP_A: state_d = nrg_pkg::ST_RD_B;
      nrg_pkg::ST_RD_B: begin
        if (b_q != a_q) begin
          state_d = nrg_pkg::ST_CAP_B;
        end else if (last_b) begin
          state_d = nrg_pkg::ST_ROW;
        end
      end
      nrg_pkg::ST_CAP_B: state_d = nrg_pkg::ST_PAIR;
      nrg_pkg::ST_PAIR:  if (pair_done) state_d = last_b ? nrg_pkg::ST_ROW : nrg_pkg::ST_RD_B;
      nrg_pkg::ST_ROW:   state_d = nrg_pkg::ST_OUT;
      nrg_pkg::ST_OUT:   if (out_acc) state_d = last_a ? nrg_pkg::ST_LOAD : nrg_pkg::ST_RD_A;
      default:           state_d = nrg_pkg::ST_LOAD;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    in_i.ready  = (state_q == nrg_pkg::ST_LOAD);
    out_o.valid = (state_q == nrg_pkg::ST_OUT);
    out_o.data  = row_q;
    store_we    = in_acc && (cnt_q < CntW'(MAX_ATOMS));
    pair_start  = (state_q == nrg_pkg::ST_CAP_B);
    rd_addr     = (state_q == nrg_pkg::ST_RD_A) ? a_q : b_q;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_hit[i] = 1'b1;
      if (acc_q[i] > 64'sd2147483647) begin
        sat_val[i] = {1'b0, {(CoordW-1){1'b1}}};
      end else if (acc_q[i] < -64'sd2147483648) begin
        sat_val[i] = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
        sat_val[i] = acc_q[i][CoordW-1:0];
        sat_hit[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nrg_pkg::ST_LOAD;
      cnt_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        nrg_pkg::ST_LOAD: begin
          if (store_we) begin
            cnt_q <= cnt_q + 1'b1;
          end
          a_q <= '0;
        end
        nrg_pkg::ST_CAP_A: b_q <= '0;
        nrg_pkg::ST_RD_B:  if (b_q == a_q && !last_b) b_q <= b_q + 1'b1;
        nrg_pkg::ST_PAIR:  if (pair_done && !last_b) b_q <= b_q + 1'b1;
        nrg_pkg::ST_OUT: begin
          if (out_acc) begin
            if (last_a) begin
              cnt_q <= '0;
            end else begin
              a_q <= a_q + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Accumulators and the result row.
  always_ff @(posedge clk_i) begin
    case (state_q)
      nrg_pkg::ST_CAP_A: begin
        atom_a_q <= rd_atom;
        for (int i = 0; i < 3; i++) begin
          acc_q[i] <= '0;
        end
        clip_q <= 1'b0;
        coin_q <= 1'b0;
      end
      nrg_pkg::ST_PAIR: begin
        if (pair_done) begin
          if (pair_res.coin) begin
            coin_q <= 1'b1;
          end else begin
            clip_q <= clip_q | pair_res.clip;
            for (int i = 0; i < 3; i++) begin
              // A positive separation pulls the gradient down, as in the energy derivative.
              if (pair_res.pos[i]) begin
                acc_q[i] <= acc_q[i] - $signed(64'(pair_res.term[i]));
              end else begin
                acc_q[i] <= acc_q[i] + $signed(64'(pair_res.term[i]));
              end
            end
          end
        end
      end
      nrg_pkg::ST_ROW: begin
        row_q.atom_idx   <= IdxOutW'(a_q);
        row_q.grad_x     <= sat_val[0];
        row_q.grad_y     <= sat_val[1];
        row_q.grad_z     <= sat_val[2];
        row_q.saturated  <= clip_q | (|sat_hit);
        row_q.coincident <= coin_q;
        row_q.row_last   <= last_a;
      end
      default: begin
      end
    endcase
  end

  nrg_atom_store #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (wr_atom),
    .raddr_i (rd_addr),
    .rdata_o (rd_atom)
  );

  nrg_pair_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pair (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pair_start),
    .req_i   (pair_req),
    .done_o  (pair_done),
    .res_o   (pair_res)
  );

endmodule
